[design/vsno_pkg.sv]
// shared constants and types for the six-neighbour occlusion block
package vsno_pkg;

	localparam int MAX_WIDTH_DEF = 64;
	localparam int MAX_DEPTH_DEF = 64;

	// size floor for every volume register, height ceiling and reset size
	localparam int SIZE_MIN   = 3;
	localparam int HEIGHT_MAX = 255;
	localparam int SIZE_RESET = 18;

	localparam int DENS_W  = 8;
	localparam int POSX_W  = 6;
	localparam int POSY_W  = 8;
	localparam int POSZ_W  = 6;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 8;

	// sum of six 8-bit values, and floor(s / 6) as (s * 1366) >> 13, exact for s < 2048
	localparam int SUM_W      = 11;
	localparam int DIV6_SHIFT = 13;
	localparam logic [SUM_W-1:0] DIV6_MUL = 11'd1366;

	typedef enum logic [CIDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_DEPTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} cfg_reg_t;

	// per-item flags from the raster tracker
	typedef struct packed {
		logic result;
		logic last;
	} tap_flags_t;

endpackage

[design/vsno_ram.sv]
// generic single-write single-read ram with registered read data
module vsno_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/vsno_raster.sv]
// volume size registers, raster counters, plane store addresses and result flags
module vsno_raster #(
	parameter int MAX_WIDTH = vsno_pkg::MAX_WIDTH_DEF,
	parameter int MAX_DEPTH = vsno_pkg::MAX_DEPTH_DEF,
	localparam int XA = $clog2(MAX_WIDTH),
	localparam int ZA = $clog2(MAX_DEPTH),
	localparam int AW = 1 + ZA + XA
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr,
	input  logic [vsno_pkg::CIDX_W-1:0]   cfg_idx,
	input  logic [vsno_pkg::CDATA_W-1:0]  cfg_wdata,
	input  logic                          step,
	output logic [XA-1:0]                 cur_x,
	output logic [ZA-1:0]                 cur_z,
	output logic [7:0]                    cur_y,
	output vsno_pkg::tap_flags_t          flags,
	output logic [AW-1:0]                 addr_wr,
	output logic [AW-1:0]                 addr_here,
	output logic [AW-1:0]                 addr_east,
	output logic [AW-1:0]                 addr_north,
	output logic [AW-1:0]                 addr_south
);

	localparam int WW = XA + 1;
	localparam int DW = ZA + 1;
	localparam int W_RST = (vsno_pkg::SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : vsno_pkg::SIZE_RESET;
	localparam int D_RST = (vsno_pkg::SIZE_RESET > MAX_DEPTH) ? MAX_DEPTH : vsno_pkg::SIZE_RESET;

	logic [WW-1:0] w_q;
	logic [DW-1:0] d_q;
	logic [7:0]    h_q;
	logic [XA-1:0] x_q;
	logic [ZA-1:0] z_q;
	logic [7:0]    y_q;

	logic [31:0]   w_raw, d_raw, h_raw;
	logic [WW-1:0] w_new;
	logic [DW-1:0] d_new;
	logic [7:0]    h_new;
	logic          x_wrap, z_wrap, y_wrap;
	logic          slot;

	// clamp the written size into its legal range
	always_comb begin
		w_raw = 32'(cfg_wdata[6:0]);
		d_raw = 32'(cfg_wdata[6:0]);
		h_raw = 32'(cfg_wdata);
		if (w_raw < 32'(vsno_pkg::SIZE_MIN)) begin
			w_new = WW'(vsno_pkg::SIZE_MIN);
		end else if (w_raw > 32'(MAX_WIDTH)) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(w_raw);
		end
		if (d_raw < 32'(vsno_pkg::SIZE_MIN)) begin
			d_new = DW'(vsno_pkg::SIZE_MIN);
		end else if (d_raw > 32'(MAX_DEPTH)) begin
			d_new = DW'(MAX_DEPTH);
		end else begin
			d_new = DW'(d_raw);
		end
		if (h_raw < 32'(vsno_pkg::SIZE_MIN)) begin
			h_new = 8'(vsno_pkg::SIZE_MIN);
		end else if (h_raw > 32'(vsno_pkg::HEIGHT_MAX)) begin
			h_new = 8'(vsno_pkg::HEIGHT_MAX);
		end else begin
			h_new = 8'(h_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			d_q <= DW'(D_RST);
			h_q <= 8'(vsno_pkg::SIZE_RESET);
		end else if (cfg_wr) begin
			unique case (vsno_pkg::cfg_reg_t'(cfg_idx))
				vsno_pkg::REG_WIDTH:  w_q <= w_new;
				vsno_pkg::REG_DEPTH:  d_q <= d_new;
				vsno_pkg::REG_HEIGHT: h_q <= h_new;
				default: ;
			endcase
		end
	end

	assign x_wrap = WW'(x_q) >= w_q - WW'(1);
	assign z_wrap = DW'(z_q) >= d_q - DW'(1);
	assign y_wrap = y_q >= h_q - 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			z_q <= '0;
			y_q <= '0;
		end else if (step) begin
			if (x_wrap) begin
				x_q <= '0;
				if (z_wrap) begin
					z_q <= '0;
					y_q <= y_wrap ? 8'd0 : y_q + 8'd1;
				end else begin
					z_q <= z_q + ZA'(1);
				end
			end else begin
				x_q <= x_q + XA'(1);
			end
		end
	end

	// the incoming item sits one plane above the centre voxel
	always_comb begin
		flags.result = (y_q >= 8'd2) && (y_q <= h_q - 8'd1)
			&& (x_q != '0) && (WW'(x_q) <= w_q - WW'(2))
			&& (z_q != '0) && (DW'(z_q) <= d_q - DW'(2));
		flags.last = (WW'(x_q) == w_q - WW'(2)) && (DW'(z_q) == d_q - DW'(2))
			&& (y_q == h_q - 8'd1);
	end

	// current slot holds plane y-2 until overwritten, the other one plane y-1
	assign slot       = y_q[0];
	assign addr_wr    = {slot, z_q, x_q};
	assign addr_here  = {~slot, z_q, x_q};
	assign addr_east  = {~slot, z_q, x_q + XA'(1)};
	assign addr_north = {~slot, z_q + ZA'(1), x_q};
	assign addr_south = {~slot, z_q - ZA'(1), x_q};

	assign cur_x = x_q;
	assign cur_z = z_q;
	assign cur_y = y_q;

endmodule

[design/vsno_kernel.sv]
// six-neighbour mean by reciprocal multiply, minus centre, clamped at zero
module vsno_kernel (
	input  logic [vsno_pkg::DENS_W-1:0] centre,
	input  logic [vsno_pkg::DENS_W-1:0] up,
	input  logic [vsno_pkg::DENS_W-1:0] down,
	input  logic [vsno_pkg::DENS_W-1:0] east,
	input  logic [vsno_pkg::DENS_W-1:0] west,
	input  logic [vsno_pkg::DENS_W-1:0] north,
	input  logic [vsno_pkg::DENS_W-1:0] south,
	output logic [vsno_pkg::DENS_W-1:0] occ
);

	localparam int PW = 2 * vsno_pkg::SUM_W;

	logic [vsno_pkg::SUM_W-1:0]  sum;
	logic [PW-1:0]               prod;
	logic [vsno_pkg::DENS_W-1:0] mean;

	always_comb begin
		sum = vsno_pkg::SUM_W'(up) + vsno_pkg::SUM_W'(down)
			+ vsno_pkg::SUM_W'(east) + vsno_pkg::SUM_W'(west)
			+ vsno_pkg::SUM_W'(north) + vsno_pkg::SUM_W'(south);
		prod = PW'(sum) * PW'(vsno_pkg::DIV6_MUL);
		mean = prod[vsno_pkg::DIV6_SHIFT +: vsno_pkg::DENS_W];
		occ  = (mean > centre) ? mean - centre : '0;
	end

endmodule

[design/volume_six_neighbour_occlusion.sv]
// top level of the streamed six-neighbour voxel occlusion block
//
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------------
//  voxel   | vox_valid / vox_stall    | density
//  result  | res_valid / res_stall    | occlusion, pos_x, pos_y, pos_z, volume_done
//  config  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one voxel per clock while vox_stall is low; a result for the item above its centre
// passes the plane store read and then the output register.
// five copies of the plane store give the five taps from earlier planes in one read.
// reset clears counters and valid flags; the plane store is not cleared.
// vox_stall rises only while the result register is full and stalled and the
// held item has a result to hand over.
module volume_six_neighbour_occlusion #(
	parameter int MAX_WIDTH = vsno_pkg::MAX_WIDTH_DEF,
	parameter int MAX_DEPTH = vsno_pkg::MAX_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [vsno_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [vsno_pkg::CDATA_W-1:0] cfg_data,
	input  logic                         vox_valid,
	output logic                         vox_stall,
	input  logic [vsno_pkg::DENS_W-1:0]  density,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [vsno_pkg::DENS_W-1:0]  occlusion,
	output logic [vsno_pkg::POSX_W-1:0]  pos_x,
	output logic [vsno_pkg::POSY_W-1:0]  pos_y,
	output logic [vsno_pkg::POSZ_W-1:0]  pos_z,
	output logic                         volume_done
);

	localparam int XA    = $clog2(MAX_WIDTH);
	localparam int ZA    = $clog2(MAX_DEPTH);
	localparam int AW    = 1 + ZA + XA;
	localparam int DEPTH = 2 ** AW;
	localparam int DW8   = vsno_pkg::DENS_W;

	logic                 accept, s1_hold, out_free;
	logic [XA-1:0]        cur_x;
	logic [ZA-1:0]        cur_z;
	logic [7:0]           cur_y;
	vsno_pkg::tap_flags_t flags;
	logic [AW-1:0]        addr_wr, addr_here, addr_east, addr_north, addr_south;

	logic [DW8-1:0] down_rd, here_rd, east_rd, north_rd, south_rd;
	logic [DW8-1:0] occ;

	logic                 valid_s1;
	vsno_pkg::tap_flags_t flags_s1;
	logic [DW8-1:0]       density_s1;
	logic [DW8-1:0]       west_s1;
	logic [XA-1:0]        x_s1;
	logic [ZA-1:0]        z_s1;
	logic [7:0]           y_s1;

	logic                 res_valid_q;
	logic [DW8-1:0]       occ_q;
	logic [vsno_pkg::POSX_W-1:0] pos_x_q;
	logic [vsno_pkg::POSY_W-1:0] pos_y_q;
	logic [vsno_pkg::POSZ_W-1:0] pos_z_q;
	logic                 done_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !res_valid_q || !res_stall;
	assign s1_hold   = valid_s1 && flags_s1.result && !out_free;
	assign vox_stall = s1_hold;
	assign accept    = vox_valid && !s1_hold;

	vsno_raster #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_DEPTH (MAX_DEPTH)
	) u_raster (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.step       (accept),
		.cur_x      (cur_x),
		.cur_z      (cur_z),
		.cur_y      (cur_y),
		.flags      (flags),
		.addr_wr    (addr_wr),
		.addr_here  (addr_here),
		.addr_east  (addr_east),
		.addr_north (addr_north),
		.addr_south (addr_south)
	);

	// every copy takes the same write; each serves one tap, the here copy the centre
	vsno_ram #(.WIDTH(DW8), .DEPTH(DEPTH)) u_ram_down (
		.clk (clk), .wr_en (accept), .wr_addr (addr_wr), .wr_data (density),
		.rd_en (accept), .rd_addr (addr_wr), .rd_data (down_rd)
	);
	vsno_ram #(.WIDTH(DW8), .DEPTH(DEPTH)) u_ram_here (
		.clk (clk), .wr_en (accept), .wr_addr (addr_wr), .wr_data (density),
		.rd_en (accept), .rd_addr (addr_here), .rd_data (here_rd)
	);
	vsno_ram #(.WIDTH(DW8), .DEPTH(DEPTH)) u_ram_east (
		.clk (clk), .wr_en (accept), .wr_addr (addr_wr), .wr_data (density),
		.rd_en (accept), .rd_addr (addr_east), .rd_data (east_rd)
	);
	vsno_ram #(.WIDTH(DW8), .DEPTH(DEPTH)) u_ram_north (
		.clk (clk), .wr_en (accept), .wr_addr (addr_wr), .wr_data (density),
		.rd_en (accept), .rd_addr (addr_north), .rd_data (north_rd)
	);
	vsno_ram #(.WIDTH(DW8), .DEPTH(DEPTH)) u_ram_south (
		.clk (clk), .wr_en (accept), .wr_addr (addr_wr), .wr_data (density),
		.rd_en (accept), .rd_addr (addr_south), .rd_data (south_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!s1_hold) begin
			valid_s1 <= accept;
		end
	end

	// the previous item was x-1 of the same row, so its centre read is the west tap
	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1   <= flags;
			density_s1 <= density;
			west_s1    <= here_rd;
			x_s1       <= cur_x;
			z_s1       <= cur_z;
			y_s1       <= cur_y;
		end
	end

	vsno_kernel u_kernel (
		.centre (here_rd),
		.up     (density_s1),
		.down   (down_rd),
		.east   (east_rd),
		.west   (west_s1),
		.north  (north_rd),
		.south  (south_rd),
		.occ    (occ)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1 && flags_s1.result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && flags_s1.result) begin
			occ_q   <= occ;
			pos_x_q <= vsno_pkg::POSX_W'(x_s1);
			pos_y_q <= vsno_pkg::POSY_W'(y_s1 - 8'd1);
			pos_z_q <= vsno_pkg::POSZ_W'(z_s1);
			done_q  <= flags_s1.last;
		end
	end

	assign res_valid   = res_valid_q;
	assign occlusion   = occ_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign pos_z       = pos_z_q;
	assign volume_done = done_q;

endmodule

[design/vsno_checker.sv]
// port-level checker for the occlusion block, bound to the top level
module vsno_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         vox_valid,
	input logic                         vox_stall,
	input logic                         res_valid,
	input logic                         res_stall,
	input logic [vsno_pkg::DENS_W-1:0]  occlusion,
	input logic [vsno_pkg::POSX_W-1:0]  pos_x,
	input logic [vsno_pkg::POSY_W-1:0]  pos_y,
	input logic [vsno_pkg::POSZ_W-1:0]  pos_z,
	input logic                         volume_done
);

	// input side only backs up behind a full, stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		vox_stall |-> res_valid && res_stall)
		else $error("vox_stall without a stalled result");

	// a fresh result needs an accepted item behind it
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(vox_valid && !vox_stall, 2))
		else $error("result without an accepted item");

	// centre voxels are never on the low margin
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pos_x != '0 && pos_y != '0 && pos_z != '0)
		else $error("result on a margin voxel");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid
			&& $stable({occlusion, pos_x, pos_y, pos_z, volume_done}))
		else $error("stalled result changed");

endmodule

bind volume_six_neighbour_occlusion vsno_checker u_vsno_checker (.*);

[tb/vsno_occlusion_checker.sv]
// watches the voxel, result and register channels, predicts each result and compares
`timescale 1ns / 100ps

module vsno_occlusion_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [vsno_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [vsno_pkg::CDATA_W-1:0] cfg_data,
	input  logic                         vox_valid,
	input  logic                         vox_stall,
	input  logic [vsno_pkg::DENS_W-1:0]  density,
	input  logic                         res_valid,
	input  logic                         res_stall,
	input  logic [vsno_pkg::DENS_W-1:0]  occlusion,
	input  logic [vsno_pkg::POSX_W-1:0]  pos_x,
	input  logic [vsno_pkg::POSY_W-1:0]  pos_y,
	input  logic [vsno_pkg::POSZ_W-1:0]  pos_z,
	input  logic                         volume_done,
	output int                           fail_count,
	output int                           pending,
	output int                           result_count
);

	localparam int FACE_COUNT = 6;
	localparam int MW = vsno_pkg::MAX_WIDTH_DEF;
	localparam int MD = vsno_pkg::MAX_DEPTH_DEF;

	typedef struct packed {
		logic [vsno_pkg::DENS_W-1:0] occ;
		logic [vsno_pkg::POSX_W-1:0] x;
		logic [vsno_pkg::POSY_W-1:0] y;
		logic [vsno_pkg::POSZ_W-1:0] z;
		logic                        done;
	} occ_result_t;

	occ_result_t occlusion_due[$];
	occ_result_t head;

	// two x-z planes, slot picked by the parity of y
	logic [vsno_pkg::DENS_W-1:0] plane_mem [2][MD][MW];

	logic [6:0] width_reg;
	logic [6:0] depth_reg;
	logic [7:0] height_reg;
	int         at_x;
	int         at_z;
	int         at_y;
	int         mismatches;
	int         results_taken;

	function automatic int fit_size(input int v, input int hi);
		if (v < vsno_pkg::SIZE_MIN)
			return vsno_pkg::SIZE_MIN;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic predict_voxel(input logic [vsno_pkg::DENS_W-1:0] dens);
		int w;
		int d;
		int h;
		int cur;
		int prv;
		int ctr;
		int sum;
		int mean;
		occ_result_t r;
		w = fit_size(int'(width_reg), MW);
		d = fit_size(int'(depth_reg), MD);
		h = fit_size(int'(height_reg), vsno_pkg::HEIGHT_MAX);
		cur = at_y % 2;
		prv = 1 - cur;
		// the item above the centre completes its six neighbours
		if (at_y >= 2 && at_y <= h - 1 && at_x >= 1 && at_x <= w - 2 &&
				at_z >= 1 && at_z <= d - 2) begin
			ctr = int'(plane_mem[prv][at_z][at_x]);
			sum = int'(dens) + int'(plane_mem[cur][at_z][at_x])
				+ int'(plane_mem[prv][at_z][at_x + 1]) + int'(plane_mem[prv][at_z][at_x - 1])
				+ int'(plane_mem[prv][at_z + 1][at_x]) + int'(plane_mem[prv][at_z - 1][at_x]);
			mean = sum / FACE_COUNT;
			r.occ = (mean > ctr) ? vsno_pkg::DENS_W'(mean - ctr) : '0;
			r.x = vsno_pkg::POSX_W'(at_x);
			r.y = vsno_pkg::POSY_W'(at_y - 1);
			r.z = vsno_pkg::POSZ_W'(at_z);
			r.done = (at_x == w - 2 && at_z == d - 2 && at_y == h - 1);
			occlusion_due.insert(occlusion_due.size(), r);
		end
		plane_mem[cur][at_z][at_x] = dens;
		if (at_x + 1 >= w) begin
			at_x = 0;
			if (at_z + 1 >= d) begin
				at_z = 0;
				at_y = (at_y + 1 >= h) ? 0 : at_y + 1;
			end else begin
				at_z = at_z + 1;
			end
		end else begin
			at_x = at_x + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occlusion_due.delete();
			width_reg = 7'(vsno_pkg::SIZE_RESET);
			depth_reg = 7'(vsno_pkg::SIZE_RESET);
			height_reg = 8'(vsno_pkg::SIZE_RESET);
			at_x = 0;
			at_z = 0;
			at_y = 0;
			mismatches = 0;
			results_taken = 0;
			fail_count <= 0;
			pending <= 0;
			result_count <= 0;
		end else begin
			// results first: one taken now always belongs to an older item
			if (res_valid && !res_stall) begin
				results_taken++;
				if (occlusion_due.size() == 0) begin
					$error("result at x=%0d y=%0d z=%0d with nothing expected",
						pos_x, pos_y, pos_z);
					mismatches++;
				end else begin
					head = occlusion_due.pop_front();
					check_field("occlusion", head.occ, occlusion);
					check_field("pos_x", head.x, pos_x);
					check_field("pos_y", head.y, pos_y);
					check_field("pos_z", head.z, pos_z);
					check_field("volume_done", head.done, volume_done);
				end
			end
			if (vox_valid && !vox_stall)
				predict_voxel(density);
			if (cfg_valid && cfg_ready) begin
				case (vsno_pkg::cfg_reg_t'(cfg_index))
					vsno_pkg::REG_WIDTH:  width_reg = cfg_data[6:0];
					vsno_pkg::REG_DEPTH:  depth_reg = cfg_data[6:0];
					vsno_pkg::REG_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			fail_count <= mismatches;
			pending <= occlusion_due.size();
			result_count <= results_taken;
		end
	end

endmodule

[tb/tb_top.sv]
// stimulus and verdict for the six-neighbour occlusion block
`timescale 1ns / 100ps

module tb_top;

	localparam int CIDX_W  = vsno_pkg::CIDX_W;
	localparam int CDATA_W = vsno_pkg::CDATA_W;
	localparam int DENS_W  = vsno_pkg::DENS_W;
	localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;
	// raster index of (1,1,1) in a 3x3x3 volume
	localparam int CUBE_CENTRE  = 13;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 900;
	localparam int SQUEEZE_AT   = 200;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CIDX_W-1:0]             cfg_index;
	logic [CDATA_W-1:0]            cfg_data;
	logic                          vox_valid;
	logic                          vox_stall;
	logic [DENS_W-1:0]             density;
	logic                          res_valid;
	logic                          res_stall;
	logic [DENS_W-1:0]             occlusion;
	logic [vsno_pkg::POSX_W-1:0]   pos_x;
	logic [vsno_pkg::POSY_W-1:0]   pos_y;
	logic [vsno_pkg::POSZ_W-1:0]   pos_z;
	logic                          volume_done;
	int                            fail_count;
	int                            pending;
	int                            result_count;

	// raster position and effective sizes as the stimulus sees them
	int tx;
	int tz;
	int ty;
	int ew;
	int ed;
	int eh;
	int voxels_sent;
	int volumes_sent;
	bit steady;

	volume_six_neighbour_occlusion DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.vox_valid   (vox_valid),
		.vox_stall   (vox_stall),
		.density     (density),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.occlusion   (occlusion),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.volume_done (volume_done)
	);

	vsno_occlusion_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.vox_valid    (vox_valid),
		.vox_stall    (vox_stall),
		.density      (density),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.occlusion    (occlusion),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.volume_done  (volume_done),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int eff_size(input int v, input int hi);
		if (v < vsno_pkg::SIZE_MIN)
			return vsno_pkg::SIZE_MIN;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [DENS_W-1:0] pick_density();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return DENS_W'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly small, sometimes below the floor, sometimes with the dropped top bit set
	function automatic logic [CDATA_W-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return CDATA_W'($urandom_range(3, 10));
		if (r < 85)
			return CDATA_W'($urandom_range(0, 2));
		return 8'h80 | CDATA_W'($urandom_range(3, 10));
	endfunction

	function automatic logic [CDATA_W-1:0] pick_height();
		if ($urandom_range(0, 99) < 85)
			return CDATA_W'($urandom_range(3, 8));
		return CDATA_W'($urandom_range(0, 2));
	endfunction

	// leaves cfg_valid high so that writes can follow back to back
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic configure(input logic [CDATA_W-1:0] wv, input logic [CDATA_W-1:0] dv,
			input logic [CDATA_W-1:0] hv);
		write_reg(vsno_pkg::REG_WIDTH, wv);
		write_reg(vsno_pkg::REG_DEPTH, dv);
		write_reg(vsno_pkg::REG_HEIGHT, hv);
		cfg_valid <= 1'b0;
		ew = eff_size(int'(wv[6:0]), vsno_pkg::MAX_WIDTH_DEF);
		ed = eff_size(int'(dv[6:0]), vsno_pkg::MAX_DEPTH_DEF);
		eh = eff_size(int'(hv), vsno_pkg::HEIGHT_MAX);
	endtask

	task automatic send_voxel(input logic [DENS_W-1:0] dens);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			vox_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vox_valid <= 1'b1;
		density <= dens;
		@(posedge clk);
		while (vox_stall)
			@(posedge clk);
		voxels_sent++;
		if (tx + 1 >= ew) begin
			tx = 0;
			if (tz + 1 >= ed) begin
				tz = 0;
				ty = (ty + 1 >= eh) ? 0 : ty + 1;
			end else begin
				tz = tz + 1;
			end
		end else begin
			tx = tx + 1;
		end
		if (tx == 0 && tz == 0 && ty == 0)
			volumes_sent++;
	endtask

	task automatic stream_volume();
		do
			send_voxel(pick_density());
		while (!(tx == 0 && tz == 0 && ty == 0));
	endtask

	// block idle: every item taken, every result out, pipeline flushed
	task automatic settle();
		vox_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int limit;
		int cut;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		vox_valid <= 1'b0;
		density <= '0;
		tx = 0;
		tz = 0;
		ty = 0;
		voxels_sent = 0;
		volumes_sent = 0;
		steady = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest volume: dark centre in a bright shell, then the reverse (clamped)
		configure(8'd3, 8'd3, 8'd3);
		for (int i = 0; i < 27; i++)
			send_voxel((i == CUBE_CENTRE) ? 8'h00 : 8'hFF);
		for (int i = 0; i < 27; i++)
			send_voxel((i == CUBE_CENTRE) ? 8'hFF : 8'h00);

		// extreme register values: below the floor, above the ceiling, dropped top bit
		settle();
		write_reg(REG_UNUSED, pick_density());
		configure(8'd0, 8'hFF, 8'd2);
		stream_volume();

		limit = voxels_sent + RANDOM_ITEMS;
		while (voxels_sent < limit) begin
			settle();
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, pick_density());
			configure(pick_dim(), pick_dim(), pick_height());
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0) begin
				// resize partway through; shrinking x and z keeps every read on written planes
				cut = $urandom_range(1, ew * ed * eh - 1);
				repeat (cut) send_voxel(pick_density());
				settle();
				configure(CDATA_W'($urandom_range(0, ew)), CDATA_W'($urandom_range(0, ed)),
					pick_height());
			end
			stream_volume();
		end
		steady = 1'b0;

		settle();
		$display("sent %0d voxels in %0d volumes, %0d results checked", voxels_sent,
			volumes_sent, result_count);
		$display("volumes 3 to 64 across, clamped register values, resizes mid-volume");
		if (pending != 0)
			$error("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// result side: random stalls, one long hold so the block backs up into the voxel side
	initial begin
		int len;
		bit squeezed;
		squeezed = 1'b0;
		res_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!squeezed && result_count >= SQUEEZE_AT) begin
				squeezed = 1'b1;
				res_stall <= 1'b1;
				len = 400;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						res_stall <= 1'b0;
						len = $urandom_range(1, 30);
					end
					5: begin
						res_stall <= 1'b0;
						len = $urandom_range(100, 300);
					end
					6, 7, 8: begin
						res_stall <= 1'b1;
						len = $urandom_range(1, 3);
					end
					default: begin
						res_stall <= 1'b1;
						len = $urandom_range(10, 50);
					end
				endcase
			end
			repeat (len) @(posedge clk);
		end
	end

	initial begin
		#30_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[volume_six_neighbour_occlusion.f]
design/vsno_pkg.sv
design/vsno_ram.sv
design/vsno_raster.sv
design/vsno_kernel.sv
design/volume_six_neighbour_occlusion.sv
design/vsno_checker.sv
tb/vsno_occlusion_checker.sv
tb/tb_top.sv
